>>> rtl/core/daq_fpp_pkg.sv
// ----------------------------------------------------------------------------
// daq_fpp_pkg
// Types, constants and codes shared by the frame parser / pedestal monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package daq_fpp_pkg;

  localparam int NUM_CHANNELS       = 64;
  localparam int EVENT_BUFFER_DEPTH = 256;

  localparam int CH_W    = 6;
  localparam int ADC_W   = 12;
  localparam int SUM_W   = 44;
  localparam int CNT_W   = 32;
  localparam int CH_AW   = $clog2(NUM_CHANNELS);
  localparam int PEND_AW = $clog2(EVENT_BUFFER_DEPTH);
  localparam int PCNT_W  = $clog2(EVENT_BUFFER_DEPTH + 1);
  localparam int PEND_W  = CH_W + ADC_W;
  localparam int DSTEP_W = $clog2(ADC_W);

  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] BYTE_MARK = 8'hBB;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_TRIG   = 3'd1,
    PH_TRAIL1 = 3'd2,
    PH_TRAIL2 = 3'd3,
    PH_WORD   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_TRIG_OK  = 3'd0,
    KIND_TRIG_ERR = 3'd1,
    KIND_HIT      = 3'd2,
    KIND_MOD_ERR  = 3'd3,
    KIND_PEDESTAL = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CM_P,
    ST_CM_S,
    ST_CM_W,
    ST_Q_LD,
    ST_Q_DIV,
    ST_Q_FIN
  } state_e;

  typedef struct packed {
    logic byte_acc;
    logic query_acc;
    logic sel_query;
    logic walk_write;
    logic walk_next;
    logic finish_commit;
    logic div_load;
    logic div_step;
    logic finish_query;
  } dp_cmd_t;

  typedef struct packed {
    logic commit_go;
    logic walk_last;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

  function automatic logic ch_in_range(input logic [CH_W-1:0] ch);
    ch_in_range = (32'(ch) < 32'(NUM_CHANNELS));
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/daq_fpp_ram.sv
// ----------------------------------------------------------------------------
// daq_fpp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module daq_fpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/daq_fpp_ctrl.sv
// ----------------------------------------------------------------------------
// daq_fpp_ctrl
// Sequencer: input handshake, commit walk and query divide steps.
// ----------------------------------------------------------------------------
`default_nettype none

module daq_fpp_ctrl import daq_fpp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    action_i,
  output logic         in_stall_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE) || sts_i.out_busy;
    acc        = in_valid_i && !in_stall_o;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.sel_query = 1'b1;
        cmd_o.byte_acc  = acc && !action_i;
        cmd_o.query_acc = acc && action_i;
        if (cmd_o.query_acc) begin
          state_d = ST_Q_LD;
        end else if (cmd_o.byte_acc && sts_i.commit_go) begin
          state_d = ST_CM_P;
        end
      end
      ST_CM_P: state_d = ST_CM_S;
      ST_CM_S: state_d = ST_CM_W;
      ST_CM_W: begin
        cmd_o.walk_write = 1'b1;
        cmd_o.walk_next  = 1'b1;
        if (sts_i.walk_last) begin
          cmd_o.finish_commit = 1'b1;
          state_d             = ST_IDLE;
        end else begin
          state_d = ST_CM_P;
        end
      end
      ST_Q_LD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_Q_DIV;
      end
      ST_Q_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_Q_FIN;
        end
      end
      ST_Q_FIN: begin
        cmd_o.finish_query = 1'b1;
        state_d            = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/daq_fpp_dp.sv
// ----------------------------------------------------------------------------
// daq_fpp_dp
// Datapath: byte parser, pending hit buffer, channel sums and counts,
// restoring divider for the mean, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module daq_fpp_dp import daq_fpp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output dp_sts_t                sts_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic [CH_W-1:0]   query_channel_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output logic [2:0]             kind_o,
  output logic [31:0]            trigger_number_o,
  output logic                   previous_event_bad_o,
  output logic [CH_W-1:0]        channel_o,
  output logic [ADC_W-1:0]       adc_value_o,
  output logic [CH_W-1:0]        module_id_o,
  output logic [ADC_W-1:0]       pedestal_o,
  output logic [CNT_W-1:0]       hit_count_o
);

  // parser state
  phase_e            ph_q, ph_n;
  logic [7:0]        prev_q, prev_n;
  logic [2:0]        hidx_q, hidx_n;
  logic [31:0]       trig_q, trig_n;
  logic [7:0]        wb1_q, wb1_n, wb2_q, wb2_n;
  logic [1:0]        widx_q, widx_n;
  logic [2:0]        fill_q, fill_n, fill_c;
  logic              err_q, err_n;
  logic [PCNT_W-1:0] pcnt_q, pcnt_n;
  logic [PCNT_W-1:0] walk_q;

  // decode / result of one byte
  logic              res_now, commit_go, pend_we;
  kind_e             r_kind;
  logic [31:0]       r_trig;
  logic              r_bad;
  logic [CH_W-1:0]   r_ch, r_mod;
  logic [ADC_W-1:0]  r_adc;
  logic [7:0]        b;

  // memories
  logic [PEND_W-1:0] pend_rd;
  logic [CH_W-1:0]   pch;
  logic [ADC_W-1:0]  padc;
  logic [CH_W-1:0]   s_raddr;
  logic [SUM_W-1:0]  sum_rd, sum_eff;
  logic [CNT_W-1:0]  cnt_rd, cnt_eff;
  logic              s_we;
  logic [NUM_CHANNELS-1:0] vld_q;
  logic              vrd_q, rok_q;

  // divider
  logic [SUM_W-1:0]   rem_q, dsh_q;
  logic [ADC_W-1:0]   quo_q;
  logic [DSTEP_W-1:0] dstep_q;
  logic [CNT_W-1:0]   dcnt_q;
  logic               ge;

  logic              out_valid_q;

  assign b = data_byte_i;

  always_comb begin
    ph_n      = ph_q;
    prev_n    = prev_q;
    hidx_n    = hidx_q;
    trig_n    = trig_q;
    wb1_n     = wb1_q;
    wb2_n     = wb2_q;
    widx_n    = widx_q;
    fill_n    = fill_q;
    err_n     = err_q;
    pcnt_n    = pcnt_q;
    res_now   = 1'b0;
    commit_go = 1'b0;
    pend_we   = 1'b0;
    r_kind    = KIND_HIT;
    r_trig    = '0;
    r_bad     = 1'b0;
    r_mod     = wb1_q[7:2];
    r_ch      = {wb1_q[1:0], wb2_q[7:4]};
    r_adc     = {wb2_q[3:0], b};
    fill_c    = fill_q + ((b == BYTE_FILL) ? 3'd1 : 3'd0);
    unique case (ph_q)
      PH_TRIG: begin
        trig_n = {trig_q[23:0], b};
        hidx_n = hidx_q + 3'd1;
        if (hidx_n >= 3'd4) begin
          hidx_n = '0;
          ph_n   = PH_TRAIL1;
        end
      end
      PH_TRAIL1: begin
        prev_n = b;
        ph_n   = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        res_now = 1'b1;
        r_trig  = trig_q;
        if (prev_q == BYTE_MARK && b == BYTE_FILL) begin
          r_kind    = KIND_TRIG_OK;
          r_bad     = err_q;
          commit_go = !err_q && (pcnt_q != '0);
        end else begin
          r_kind = KIND_TRIG_ERR;
        end
        if (!commit_go) begin
          pcnt_n = '0;
        end
        err_n  = 1'b0;
        prev_n = b;
        ph_n   = PH_HUNT;
      end
      PH_WORD: begin
        widx_n = widx_q + 2'd1;
        if (widx_q == 2'd1) wb1_n = b;
        if (widx_q == 2'd2) wb2_n = b;
        if (widx_q == 2'd3) begin
          fill_n = '0;
          if (fill_c >= 3'd2) begin
            prev_n = b;
            ph_n   = PH_HUNT;
          end else begin
            res_now = 1'b1;
            if (r_mod != '0) begin
              err_n  = 1'b1;
              r_kind = KIND_MOD_ERR;
            end
            if (err_n) begin
              pcnt_n = '0;
            end else if (pcnt_q < PCNT_W'(EVENT_BUFFER_DEPTH)) begin
              pend_we = 1'b1;
              pcnt_n  = pcnt_q + 1'b1;
            end else begin
              r_kind = KIND_OVERFLOW;
            end
          end
        end else begin
          fill_n = fill_c;
        end
      end
      default: begin
        prev_n = b;
        ph_n   = PH_HUNT;
        if (prev_q == BYTE_FILL && b == BYTE_MARK) begin
          ph_n   = PH_TRIG;
          hidx_n = '0;
          trig_n = '0;
        end else if (prev_q == BYTE_FILL && b != BYTE_FILL) begin
          ph_n   = PH_WORD;
          widx_n = 2'd1;
          fill_n = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_HUNT;
      prev_q <= '0;
      hidx_q <= '0;
      trig_q <= '0;
      wb1_q  <= '0;
      wb2_q  <= '0;
      widx_q <= '0;
      fill_q <= '0;
      err_q  <= 1'b0;
      pcnt_q <= '0;
      walk_q <= '0;
    end else begin
      if (cmd_i.byte_acc) begin
        ph_q   <= ph_n;
        prev_q <= prev_n;
        hidx_q <= hidx_n;
        trig_q <= trig_n;
        wb1_q  <= wb1_n;
        wb2_q  <= wb2_n;
        widx_q <= widx_n;
        fill_q <= fill_n;
        err_q  <= err_n;
        walk_q <= '0;
      end else if (cmd_i.walk_next) begin
        walk_q <= walk_q + 1'b1;
      end
      if (cmd_i.finish_commit) begin
        pcnt_q <= '0;
      end else if (cmd_i.byte_acc) begin
        pcnt_q <= pcnt_n;
      end
    end
  end

  daq_fpp_ram #(.WIDTH(PEND_W), .DEPTH(EVENT_BUFFER_DEPTH)) u_pend (
    .clk_i   (clk_i),
    .we_i    (cmd_i.byte_acc && pend_we),
    .waddr_i (pcnt_q[PEND_AW-1:0]),
    .wdata_i ({r_ch, r_adc}),
    .raddr_i (walk_q[PEND_AW-1:0]),
    .rdata_o (pend_rd)
  );

  assign pch     = pend_rd[PEND_W-1:ADC_W];
  assign padc    = pend_rd[ADC_W-1:0];
  assign s_raddr = cmd_i.sel_query ? query_channel_i : pch;

  assign sum_eff = (vrd_q && rok_q) ? sum_rd : '0;
  assign cnt_eff = (vrd_q && rok_q) ? cnt_rd : '0;
  assign s_we    = cmd_i.walk_write && rok_q && (cnt_eff != '1);

  daq_fpp_ram #(.WIDTH(SUM_W), .DEPTH(NUM_CHANNELS)) u_sum (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (pch[CH_AW-1:0]),
    .wdata_i (sum_eff + SUM_W'(padc)),
    .raddr_i (s_raddr[CH_AW-1:0]),
    .rdata_o (sum_rd)
  );

  daq_fpp_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CHANNELS)) u_cnt (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (pch[CH_AW-1:0]),
    .wdata_i (cnt_eff + 1'b1),
    .raddr_i (s_raddr[CH_AW-1:0]),
    .rdata_o (cnt_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vrd_q <= 1'b0;
      rok_q <= 1'b0;
    end else begin
      if (s_we) begin
        vld_q[pch[CH_AW-1:0]] <= 1'b1;
      end
      vrd_q <= vld_q[s_raddr[CH_AW-1:0]];
      rok_q <= ch_in_range(s_raddr);
    end
  end

  // restoring divide, one quotient bit per cycle, mean is below 2^ADC_W
  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q   <= sum_eff;
      dsh_q   <= SUM_W'(cnt_eff) << (ADC_W - 1);
      quo_q   <= '0;
      dcnt_q  <= cnt_eff;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? (rem_q - dsh_q) : rem_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[ADC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstep_q <= '0;
    end else if (cmd_i.div_load) begin
      dstep_q <= '0;
    end else if (cmd_i.div_step) begin
      dstep_q <= dstep_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((cmd_i.byte_acc && res_now && !commit_go) || cmd_i.finish_commit ||
          cmd_i.finish_query) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_acc && res_now) begin
      kind_o               <= r_kind;
      trigger_number_o     <= r_trig;
      previous_event_bad_o <= r_bad;
      channel_o            <= (r_trig == '0 && !(ph_q == PH_TRAIL2)) ? r_ch : '0;
      adc_value_o          <= (ph_q == PH_TRAIL2) ? '0 : r_adc;
      module_id_o          <= (ph_q == PH_TRAIL2) ? '0 : r_mod;
      pedestal_o           <= '0;
      hit_count_o          <= '0;
    end else if (cmd_i.query_acc) begin
      kind_o               <= KIND_PEDESTAL;
      trigger_number_o     <= '0;
      previous_event_bad_o <= 1'b0;
      channel_o            <= query_channel_i;
      adc_value_o          <= '0;
      module_id_o          <= '0;
      pedestal_o           <= '0;
      hit_count_o          <= '0;
    end else if (cmd_i.finish_query) begin
      pedestal_o  <= (dcnt_q == '0) ? '0 : quo_q;
      hit_count_o <= dcnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o           = '0;
    sts_o.commit_go = commit_go;
    sts_o.walk_last = (walk_q + 1'b1) == pcnt_q;
    sts_o.div_done  = dstep_q == DSTEP_W'(ADC_W - 1);
    sts_o.out_busy  = out_valid_q && out_stall_i;
  end

endmodule

`default_nettype wire

>>> rtl/core/daq_frame_parser_pedestal.sv
// ----------------------------------------------------------------------------
// daq_frame_parser_pedestal
// Readout byte parser with per-channel pedestal accumulation and query.
// ----------------------------------------------------------------------------
// channel  signals                         handshake
// in       action, data_byte, query_ch     in_valid_i / in_stall_o
// out      kind .. hit_count               out_valid_o / out_stall_i
//
// A good trailer of a clean event walks the pending buffer hit by hit, each
// hit as buffer read, sum/count RAM read, then write-back. A query runs the
// 12-step restoring divider. No clearing pass after reset: per-channel valid
// flops read unwritten channels as zero. A held result stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module daq_frame_parser_pedestal import daq_fpp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              action_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic [CH_W-1:0]   query_channel_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             kind_o,
  output logic [31:0]            trigger_number_o,
  output logic                   previous_event_bad_o,
  output logic [CH_W-1:0]        channel_o,
  output logic [ADC_W-1:0]       adc_value_o,
  output logic [CH_W-1:0]        module_id_o,
  output logic [ADC_W-1:0]       pedestal_o,
  output logic [CNT_W-1:0]       hit_count_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  daq_fpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  daq_fpp_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .data_byte_i          (data_byte_i),
    .query_channel_i      (query_channel_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .kind_o               (kind_o),
    .trigger_number_o     (trigger_number_o),
    .previous_event_bad_o (previous_event_bad_o),
    .channel_o            (channel_o),
    .adc_value_o          (adc_value_o),
    .module_id_o          (module_id_o),
    .pedestal_o           (pedestal_o),
    .hit_count_o          (hit_count_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/daq_fpp_checker.sv
// ----------------------------------------------------------------------------
// daq_fpp_checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module daq_fpp_checker import daq_fpp_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [2:0]        kind_o,
  input wire logic [31:0]       trigger_number_o,
  input wire logic [CH_W-1:0]   module_id_o,
  input wire logic [ADC_W-1:0]  pedestal_o,
  input wire logic [CNT_W-1:0]  hit_count_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o))
    else $error("result word dropped while stalled");

  a_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_MOD_ERR |-> module_id_o != '0)
    else $error("module error with zero module");

  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_HIT || kind_o == KIND_OVERFLOW ||
                    kind_o == KIND_MOD_ERR) |-> trigger_number_o == '0)
    else $error("hit word carries trigger number");

  a_ped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PEDESTAL && hit_count_o == '0 |-> pedestal_o == '0)
    else $error("nonzero pedestal without hits");

endmodule

bind daq_frame_parser_pedestal daq_fpp_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .trigger_number_o (trigger_number_o),
  .module_id_o      (module_id_o),
  .pedestal_o       (pedestal_o),
  .hit_count_o      (hit_count_o)
);

`default_nettype wire

>>> verif/daq_frame_parser_pedestal_tb.sv
// ----------------------------------------------------------------------------
// daq_frame_parser_pedestal_tb
// Self-checking bench: drives readout bytes and pedestal queries with random
// gaps on both sides, predicts every result from its own parser model and
// compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module daq_frame_parser_pedestal_tb;
  import daq_fpp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] trig;
    logic        bad;
    logic [5:0]  ch;
    logic [11:0] adc;
    logic [5:0]  modid;
    logic [11:0] ped;
    logic [31:0] cnt;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic [5:0] query_channel_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] kind_o;
  logic [31:0] trigger_number_o;
  logic previous_event_bad_o;
  logic [5:0] channel_o;
  logic [11:0] adc_value_o;
  logic [5:0] module_id_o;
  logic [11:0] pedestal_o;
  logic [31:0] hit_count_o;

  daq_frame_parser_pedestal i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .data_byte_i,
    .query_channel_i, .out_valid_o, .out_stall_i, .kind_o, .trigger_number_o,
    .previous_event_bad_o, .channel_o, .adc_value_o, .module_id_o,
    .pedestal_o, .hit_count_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // parser model state
  phase_e      m_phase;
  logic [7:0]  m_prev;
  int unsigned m_hdr_idx;
  logic [31:0] m_trig;
  logic [7:0]  m_wb [4];
  int unsigned m_widx;
  int unsigned m_fill;
  logic        m_err;
  logic [5:0]  m_pch [EVENT_BUFFER_DEPTH];
  logic [11:0] m_padc [EVENT_BUFFER_DEPTH];
  int unsigned m_pcnt;
  logic [43:0] m_sum [NUM_CHANNELS];
  logic [31:0] m_cnt [NUM_CHANNELS];

  result_t expected_q [$];
  int  failures = 0;
  int  words_sent = 0;
  bit  idle_on = 1'b1;
  longint cycles = 0;

  function automatic void model_reset();
    m_phase = PH_HUNT; m_prev = '0; m_hdr_idx = 0; m_trig = '0;
    for (int i = 0; i < 4; i++) m_wb[i] = '0;
    m_widx = 0; m_fill = 0; m_err = 1'b0; m_pcnt = 0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      m_sum[i] = '0;
      m_cnt[i] = '0;
    end
  endfunction

  function automatic bit parse_step(logic act, logic [7:0] b, logic [5:0] qch,
                                    output result_t r);
    logic [5:0] md, ch;
    logic [11:0] adc;
    r = '0;
    if (act) begin
      r.kind = KIND_PEDESTAL;
      r.ch = qch;
      if (m_cnt[qch] != 0) begin
        r.ped = 12'(m_sum[qch] / m_cnt[qch]);
        r.cnt = m_cnt[qch];
      end
      return 1'b1;
    end
    case (m_phase)
      PH_TRIG: begin
        m_trig = {m_trig[23:0], b};
        m_hdr_idx++;
        if (m_hdr_idx >= 4) begin
          m_hdr_idx = 0;
          m_phase = PH_TRAIL1;
        end
        return 1'b0;
      end
      PH_TRAIL1: begin
        m_prev = b;
        m_phase = PH_TRAIL2;
        return 1'b0;
      end
      PH_TRAIL2: begin
        r.trig = m_trig;
        if (m_prev == BYTE_MARK && b == BYTE_FILL) begin
          if (!m_err) begin
            for (int i = 0; i < m_pcnt; i++) begin
              if (m_cnt[m_pch[i]] != 32'hFFFF_FFFF) begin
                m_cnt[m_pch[i]]++;
                m_sum[m_pch[i]] += m_padc[i];
              end
            end
          end
          r.kind = KIND_TRIG_OK;
          r.bad = m_err;
        end else begin
          r.kind = KIND_TRIG_ERR;
        end
        m_pcnt = 0; m_err = 1'b0; m_prev = b; m_phase = PH_HUNT;
        return 1'b1;
      end
      PH_WORD: begin
        m_wb[m_widx] = b;
        if (b == BYTE_FILL) m_fill++;
        m_widx = (m_widx + 1) % 4;
        if (m_widx != 0) return 1'b0;
        if (m_fill >= 2) begin
          m_fill = 0; m_prev = b; m_phase = PH_HUNT;
          return 1'b0;
        end
        m_fill = 0;
        md = m_wb[1][7:2];
        ch = {m_wb[1][1:0], m_wb[2][7:4]};
        adc = {m_wb[2][3:0], m_wb[3]};
        r.kind = KIND_HIT;
        if (md != 0) begin
          m_err = 1'b1;
          r.kind = KIND_MOD_ERR;
        end
        if (m_err) m_pcnt = 0;
        else if (m_pcnt < EVENT_BUFFER_DEPTH) begin
          m_pch[m_pcnt] = ch;
          m_padc[m_pcnt] = adc;
          m_pcnt++;
        end else r.kind = KIND_OVERFLOW;
        r.ch = ch; r.adc = adc; r.modid = md;
        return 1'b1;
      end
      default: begin
        if (m_prev == BYTE_FILL && b == BYTE_MARK) begin
          m_phase = PH_TRIG; m_hdr_idx = 0; m_trig = '0;
        end else if (m_prev == BYTE_FILL && b != BYTE_FILL) begin
          m_phase = PH_WORD; m_wb[0] = b; m_widx = 1; m_fill = 0;
        end else m_phase = PH_HUNT;
        m_prev = b;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_word(logic act, logic [7:0] b, logic [5:0] qch);
    result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    data_byte_i <= b;
    query_channel_i <= qch;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    words_sent++;
    if (parse_step(act, b, qch, r)) expected_q.push_back(r);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(1'b0, b, 6'($urandom));
  endtask

  task automatic send_query(logic [5:0] ch);
    send_word(1'b1, 8'($urandom), ch);
  endtask

  task automatic send_header(logic [31:0] trig, logic [7:0] t1, logic [7:0] t2);
    send_byte(BYTE_FILL);
    send_byte(BYTE_MARK);
    for (int i = 3; i >= 0; i--) send_byte(trig[i*8 +: 8]);
    send_byte(t1);
    send_byte(t2);
  endtask

  task automatic send_hit(logic [5:0] md, logic [5:0] ch, logic [11:0] adc);
    send_byte(8'($urandom_range(0, 8'hBA)));
    send_byte({md, ch[5:4]});
    send_byte({ch[3:0], adc[11:8]});
    send_byte(adc[7:0]);
  endtask

  task automatic send_data_end();
    repeat (4) send_byte(BYTE_FILL);
  endtask

  // one event: header, then hits that the next good trailer commits
  task automatic send_event(int nhits, int bad_pct, bit broken);
    logic [7:0] t1, t2;
    t1 = BYTE_MARK;
    t2 = BYTE_FILL;
    if (broken) begin
      if ($urandom_range(0, 1)) t1 = 8'($urandom);
      else t2 = 8'($urandom_range(0, 8'hFE));
    end
    send_header($urandom, t1, t2);
    if (t2 != BYTE_FILL) send_byte(BYTE_FILL);
    for (int i = 0; i < nhits; i++) begin
      if ($urandom_range(0, 99) < bad_pct)
        send_hit(6'($urandom_range(1, 63)), 6'($urandom), 12'($urandom));
      else
        send_hit(6'd0, 6'($urandom), 12'($urandom));
      if ($urandom_range(0, 9) == 0) send_query(6'($urandom));
    end
    send_data_end();
  endtask

  task automatic test_empty_query();
    send_query(6'd0);
    send_query(6'd63);
  endtask

  task automatic test_clean_event();
    send_header(32'h0000_0000, BYTE_MARK, BYTE_FILL);
    send_hit(6'd0, 6'd0, 12'd0);
    send_hit(6'd0, 6'd63, 12'hFFF);
    send_hit(6'd0, 6'd63, 12'd1);
    send_data_end();
    send_header(32'hFFFF_FFFF, BYTE_MARK, BYTE_FILL);
    send_query(6'd63);
    send_query(6'd0);
  endtask

  task automatic test_bad_module();
    send_hit(6'd0, 6'd5, 12'h123);
    send_hit(6'd63, 6'd5, 12'h456);
    send_hit(6'd0, 6'd5, 12'h789);
    send_data_end();
    send_header(32'h1234_5678, BYTE_MARK, BYTE_FILL);
    send_query(6'd5);
  endtask

  task automatic test_bad_trailer();
    send_event(2, 0, 1'b1);
    send_event(2, 0, 1'b1);
    send_event(0, 0, 1'b0);
  endtask

  task automatic test_overflow();
    send_event(EVENT_BUFFER_DEPTH + 3, 0, 1'b0);
    send_event(0, 0, 1'b0);
    send_query(6'($urandom));
  endtask

  task automatic test_random(int target);
    int start;
    start = words_sent;
    while (words_sent - start < target) begin
      case ($urandom_range(0, 9))
        0: send_byte(8'($urandom));
        1: send_query(6'($urandom));
        2: send_event($urandom_range(0, 6), 30, 1'b1);
        3: send_hit(6'($urandom), 6'($urandom), 12'($urandom));
        default: send_event($urandom_range(0, 8), 5, 1'b0);
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!idle_on) out_stall_i <= 1'b0;
    else if (stall_left > 0) stall_left <= stall_left - 1;
    else if ($urandom_range(0, 4) == 0) begin
      out_stall_i <= ~out_stall_i;
      stall_left <= $urandom_range(1, 7);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(negedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result, kind %0d", kind_o);
        failures++;
      end else begin
        e = expected_q.pop_front();
        check_field("kind", 32'(e.kind), 32'(kind_o));
        check_field("trigger_number", e.trig, trigger_number_o);
        check_field("previous_event_bad", 32'(e.bad), 32'(previous_event_bad_o));
        check_field("channel", 32'(e.ch), 32'(channel_o));
        check_field("adc_value", 32'(e.adc), 32'(adc_value_o));
        check_field("module_id", 32'(e.modid), 32'(module_id_o));
        check_field("pedestal", 32'(e.ped), 32'(pedestal_o));
        check_field("hit_count", e.cnt, hit_count_o);
      end
    end
  end

  initial begin
    model_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_query();
    test_clean_event();
    test_bad_module();
    test_bad_trailer();
    test_overflow();
    test_random(600);
    idle_on = 1'b0;
    test_random(150);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (expected_q.size() != 0) $error("%0d results missing", expected_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/daq_fpp_pkg.sv
rtl/core/daq_fpp_ram.sv
rtl/core/daq_fpp_ctrl.sv
rtl/core/daq_fpp_dp.sv
rtl/core/daq_frame_parser_pedestal.sv
rtl/core/daq_fpp_checker.sv
verif/daq_frame_parser_pedestal_tb.sv
